### hdl/insp_pkg.sv
// ----------------------------------------------------------------------------
// insp_pkg: shared constants and types for the in-sphere predicate
// Holds the fixed register codes and the stage record passed between stages.
// ----------------------------------------------------------------------------
package insp_pkg;

   localparam int unsigned CSR_WIDTH     = 48;
   localparam int unsigned CSR_IDX_WIDTH = 2;

   localparam logic [CSR_IDX_WIDTH-1:0] REG_VERTEX_ZERO  = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_VERTEX_ONE   = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_VERTEX_TWO   = 2'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_VERTEX_THREE = 2'd3;

   // Control record that travels with each item down the pipeline.
   typedef struct packed {
      logic valid;
   } stage_ctl_type;

endpackage

### hdl/insp_det3.sv
// ----------------------------------------------------------------------------
// insp_det3: pipelined 3x3 determinant times a lift term
// Four register stages: 2x2 minors, 3x3 determinant, two half products with
// the lift, and their sum.
// ----------------------------------------------------------------------------
module insp_det3 #(
   parameter int DW = 17,
   parameter int NW = 36,
   parameter int OW = 110
) (
   input  logic                 clock,
   input  logic signed [DW-1:0] a0, a1, a2,
   input  logic signed [DW-1:0] b0, b1, b2,
   input  logic signed [DW-1:0] c0, c1, c2,
   input  logic signed [NW-1:0] lift,
   output logic signed [OW-1:0] prod
);
   localparam int MW  = 2*DW + 1;
   localparam int TW  = 3*DW + 3;
   // The determinant is split in a low unsigned half and a high signed half
   // so that each product with the lift stays near 32 by 32 bits.
   localparam int LW  = TW / 2;
   localparam int HW  = TW - LW;
   localparam int PHW = NW + HW;
   localparam int PLW = NW + LW + 1;

   logic signed [MW-1:0]  m0_ff, m1_ff, m2_ff;
   logic signed [DW-1:0]  a0_ff, a1_ff, a2_ff;
   logic signed [NW-1:0]  lift_ff;
   logic signed [TW-1:0]  det_ff;
   logic signed [PHW-1:0] ph_ff;
   logic signed [PLW-1:0] pl_ff;
   logic signed [OW-1:0]  prod_ff;

   always_ff @(posedge clock) begin
      m0_ff   <= MW'(b1*c2) - MW'(b2*c1);
      m1_ff   <= MW'(b0*c2) - MW'(b2*c0);
      m2_ff   <= MW'(b0*c1) - MW'(b1*c0);
      a0_ff   <= a0;
      a1_ff   <= a1;
      a2_ff   <= a2;
      lift_ff <= lift;
      det_ff  <= TW'(a0_ff*m0_ff) - TW'(a1_ff*m1_ff) + TW'(a2_ff*m2_ff);
      ph_ff   <= PHW'(lift_ff * $signed(det_ff[TW-1:LW]));
      pl_ff   <= PLW'(lift_ff * $signed({1'b0, det_ff[LW-1:0]}));
      prod_ff <= (OW'(ph_ff) <<< LW) + OW'(pl_ff);
   end

   assign prod = prod_ff;
endmodule

### hdl/insphere_predicate_3d_top.sv
// ----------------------------------------------------------------------------
// insphere_predicate_3d_top: exact in-sphere test against a fixed tetrahedron
// Streams query points and reports whether each lies inside the circumsphere.
// ----------------------------------------------------------------------------
// Usage: write the four tetrahedron vertices through the csr_ port
// (csr_we, csr_idx, csr_wdata; x in the low field, then y, then z). Writes
// take effect at once; indexes above three are ignored. Each query enters
// on req_query_x/y/z at an edge where start is high and busy is low. busy
// is always low, so a new item may enter every cycle.
// Each item gives one result: rsp_inside_res, marked by rsp_valid for one
// cycle, once the item has passed every stage. The stages are: vertex
// minus query, squares, lift sum beside the 2x2 minors, the 3x3 cofactors,
// two half products with the lift term, their sum, and the final signed
// sum of four products with the sign test. The depth is set by keeping
// every multiplier near 32 by 32 bits. Throughput is one item per cycle.
// Reset clears the vertices to zero and empties the pipeline valid bits.
// The receiver cannot stall, so results are never held back.
// ----------------------------------------------------------------------------
module insphere_predicate_3d_top #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [COORD_WIDTH-1:0]         req_query_x,
   input  logic signed [COORD_WIDTH-1:0]         req_query_y,
   input  logic signed [COORD_WIDTH-1:0]         req_query_z,
   output logic                                  rsp_valid,
   output logic                                  rsp_inside_res,
   input  logic                                  csr_we,
   input  logic [insp_pkg::CSR_IDX_WIDTH-1:0]    csr_idx,
   input  logic [insp_pkg::CSR_WIDTH-1:0]        csr_wdata
);
   localparam int W   = COORD_WIDTH;
   localparam int DW  = W + 1;
   localparam int NW  = 2*DW + 2;
   localparam int OW  = NW + 3*DW + 3;
   localparam int AW  = OW + 2;
   localparam int LAT = 7;

   logic [3*W-1:0] vtx_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) vtx_ff[i] <= '0;
      end else if (csr_we) begin
         case (csr_idx)
            insp_pkg::REG_VERTEX_ZERO:  vtx_ff[0] <= csr_wdata[3*W-1:0];
            insp_pkg::REG_VERTEX_ONE:   vtx_ff[1] <= csr_wdata[3*W-1:0];
            insp_pkg::REG_VERTEX_TWO:   vtx_ff[2] <= csr_wdata[3*W-1:0];
            insp_pkg::REG_VERTEX_THREE: vtx_ff[3] <= csr_wdata[3*W-1:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // Stage 1: differences from the query point.
   logic signed [DW-1:0] d_ff [4][3];
   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         d_ff[i][0] <= DW'($signed(vtx_ff[i][W-1:0]))     - DW'(req_query_x);
         d_ff[i][1] <= DW'($signed(vtx_ff[i][2*W-1:W]))   - DW'(req_query_y);
         d_ff[i][2] <= DW'($signed(vtx_ff[i][3*W-1:2*W])) - DW'(req_query_z);
      end
   end

   // Lift terms: squares registered, then summed; runs beside the minors.
   logic signed [NW-1:0] sq_ff [4][3];
   logic signed [NW-1:0] n_ff [4];
   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         for (int k = 0; k < 3; k++) sq_ff[i][k] <= NW'(d_ff[i][k] * d_ff[i][k]);
         n_ff[i] <= sq_ff[i][0] + sq_ff[i][1] + sq_ff[i][2];
      end
   end

   // Differences delayed one stage so the minors line up with n inside the cofactor units.
   logic signed [DW-1:0] dd_ff [4][3];
   always_ff @(posedge clock) begin
      dd_ff <= d_ff;
   end

   logic signed [OW-1:0] t [4];
   // Row i is dropped from the minor; the three others form it in order.
   insp_det3 #(.DW(DW), .NW(NW), .OW(OW)) u_c0 (
      .clock(clock),
      .a0(dd_ff[1][0]), .a1(dd_ff[1][1]), .a2(dd_ff[1][2]),
      .b0(dd_ff[2][0]), .b1(dd_ff[2][1]), .b2(dd_ff[2][2]),
      .c0(dd_ff[3][0]), .c1(dd_ff[3][1]), .c2(dd_ff[3][2]),
      .lift(n_ff[0]), .prod(t[0]));
   insp_det3 #(.DW(DW), .NW(NW), .OW(OW)) u_c1 (
      .clock(clock),
      .a0(dd_ff[0][0]), .a1(dd_ff[0][1]), .a2(dd_ff[0][2]),
      .b0(dd_ff[2][0]), .b1(dd_ff[2][1]), .b2(dd_ff[2][2]),
      .c0(dd_ff[3][0]), .c1(dd_ff[3][1]), .c2(dd_ff[3][2]),
      .lift(n_ff[1]), .prod(t[1]));
   insp_det3 #(.DW(DW), .NW(NW), .OW(OW)) u_c2 (
      .clock(clock),
      .a0(dd_ff[0][0]), .a1(dd_ff[0][1]), .a2(dd_ff[0][2]),
      .b0(dd_ff[1][0]), .b1(dd_ff[1][1]), .b2(dd_ff[1][2]),
      .c0(dd_ff[3][0]), .c1(dd_ff[3][1]), .c2(dd_ff[3][2]),
      .lift(n_ff[2]), .prod(t[2]));
   insp_det3 #(.DW(DW), .NW(NW), .OW(OW)) u_c3 (
      .clock(clock),
      .a0(dd_ff[0][0]), .a1(dd_ff[0][1]), .a2(dd_ff[0][2]),
      .b0(dd_ff[1][0]), .b1(dd_ff[1][1]), .b2(dd_ff[1][2]),
      .c0(dd_ff[2][0]), .c1(dd_ff[2][1]), .c2(dd_ff[2][2]),
      .lift(n_ff[3]), .prod(t[3]));

   // Final stage: signs -, +, -, + along the lifted column, then sign test.
   logic signed [AW-1:0] acc;
   logic                 inside_ff;
   assign acc = AW'(t[1]) + AW'(t[3]) - AW'(t[0]) - AW'(t[2]);
   always_ff @(posedge clock) begin
      inside_ff <= (acc > 0);
   end

   // Valid bits travel alongside the data stages.
   insp_pkg::stage_ctl_type ctl_ff [LAT];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < LAT; s++) ctl_ff[s].valid <= 1'b0;
      end else begin
         ctl_ff[0].valid <= start;
         for (int s = 1; s < LAT; s++) ctl_ff[s] <= ctl_ff[s-1];
      end
   end

   assign rsp_valid      = ctl_ff[LAT-1].valid;
   assign rsp_inside_res = inside_ff;

`ifndef SYNTHESIS
   a_lat: assert property (@(posedge clock) disable iff (reset)
      ctl_ff[0].valid |-> ##(LAT-1) rsp_valid)
      else $error("accepted item did not produce a result");
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LAT))
      else $error("result without an accepted item");
   a_busy: assert property (@(posedge clock) !busy)
      else $error("busy raised");
`endif
endmodule
